// ===== hdl/dsdpm_pkg.sv =====
// Package for the DSD/PCM meter decimator: payload types, codes and the popcount function.
package dsdpm_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 7;
   localparam int unsigned QUOT_W   = 16;
   localparam int unsigned POP_W    = 6;

   localparam logic [CSR_IDX_W-1:0] REG_FORMAT_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DECIMATION    = 2'd2;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_S16  = 2'd1;
   localparam logic [1:0] MODE_S32  = 2'd2;
   localparam logic [1:0] MODE_DSD  = 2'd3;

   localparam logic [1:0] RESET_FORMAT_MODE   = MODE_NONE;
   localparam logic [1:0] RESET_CHANNEL_COUNT = 2'd2;
   localparam logic [6:0] RESET_DECIMATION    = 7'd1;

   typedef struct packed {
      logic [WORD_W-1:0] left_word;
      logic [WORD_W-1:0] right_word;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_PUSH
   } state_type;

   // adder tree, five levels
   function automatic logic [POP_W-1:0] popcount32(input logic [WORD_W-1:0] w);
      logic [1:0] s1 [16];
      logic [2:0] s2 [8];
      logic [3:0] s3 [4];
      logic [4:0] s4 [2];
      for (int i = 0; i < 16; i++) s1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
      for (int i = 0; i < 8; i++)  s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
      for (int i = 0; i < 4; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
      for (int i = 0; i < 2; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
      return {1'b0, s4[0]} + {1'b0, s4[1]};
   endfunction

endpackage

// ===== hdl/dsd_pcm_meter_decimator.sv =====
// Top level: DSD/PCM level-meter decimator with a shared iterative divider.
// PCM modes: a taken item's samples are registered, then the push state loads the result
// register; no new item is taken until the push is done. DSD frames that do not close a
// window stay idle and only update the counts. A closing frame runs the restoring divider,
// one quotient bit per cycle, per channel. While a held result is stalled, push waits and input stalls.
// Synchronous active-high reset: registers to defaults, counts cleared, no result held.
module dsd_pcm_meter_decimator
   import dsdpm_pkg::*;
#(
   parameter int unsigned MAX_DECIMATION = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned FW  = $clog2(MAX_DECIMATION + 1);
   localparam int unsigned CW  = FW + 5;
   localparam int unsigned DVW = FW + 3;
   localparam int unsigned NW  = CW + 15;

   state_type state_ff, state_in;

   logic [1:0]            mode_ff, mode_in;
   logic [1:0]            chans_ff, chans_in;
   logic [6:0]            dec_ff, dec_in;
   logic [CW-1:0]         ones_l_ff, ones_l_in;
   logic [CW-1:0]         ones_r_ff, ones_r_in;
   logic [FW-1:0]         frames_ff, frames_in;
   logic                  chan_ff, chan_in;
   logic [3:0]            step_ff, step_in;
   logic                  neg_ff, neg_in;
   logic [DVW-1:0]        rem_ff, rem_in;
   logic [QUOT_W-1:0]     low_ff, low_in;
   logic [SAMPLE_W-1:0]   lsamp_ff, lsamp_in;
   logic [SAMPLE_W-1:0]   rsamp_ff, rsamp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  req_take;
   logic                  stereo;
   logic                  rsp_free;
   logic [FW-1:0]         n_eff;
   logic [FW-1:0]         frames_next;
   logic                  window_done;
   logic                  div_last;
   logic [DVW-1:0]        divisor;
   logic [CW-1:0]         cnt_sel;
   logic [CW-1:0]         base;
   logic                  cnt_neg;
   logic [CW-1:0]         mag;
   logic [NW-1:0]         num;
   logic [DVW:0]          trial;
   logic [DVW:0]          diff;
   logic                  ge;
   logic [QUOT_W-1:0]     quot;
   logic [SAMPLE_W-1:0]   sat_mag;
   logic [SAMPLE_W-1:0]   level;
   logic                  cfg_hit;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign stereo    = chans_ff[1];
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (dec_ff == '0) begin
         n_eff = FW'(1);
      end else if (32'(dec_ff) > MAX_DECIMATION) begin
         n_eff = FW'(MAX_DECIMATION);
      end else begin
         n_eff = FW'(dec_ff);
      end
   end

   assign frames_next = FW'(frames_ff + 1'b1);
   assign window_done = (frames_next >= n_eff);
   assign div_last    = (step_ff == 4'd15);

   // shared divider datapath
   assign divisor = {frames_ff, 3'b000};
   assign cnt_sel = chan_ff ? ones_r_ff : ones_l_ff;
   assign base    = {1'b0, frames_ff, 4'b0000};
   assign cnt_neg = (cnt_sel < base);
   assign mag     = cnt_neg ? (base - cnt_sel) : (cnt_sel - base);
   assign num     = {mag, 15'd0} - {15'd0, mag};
   assign trial   = {rem_ff, low_ff[QUOT_W-1]};
   assign ge      = (trial >= {1'b0, divisor});
   assign diff    = trial - {1'b0, divisor};
   assign quot    = {low_ff[QUOT_W-2:0], ge};
   assign sat_mag = quot[QUOT_W-1] ? 16'h7FFF : {1'b0, quot[QUOT_W-2:0]};
   assign level   = neg_ff ? (16'd0 - sat_mag) : sat_mag;

   assign cfg_hit = csr_we && (csr_index == REG_FORMAT_MODE ||
                               csr_index == REG_CHANNEL_COUNT ||
                               csr_index == REG_DECIMATION);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (mode_ff) inside
                  MODE_NONE:          state_in = ST_IDLE;
                  MODE_S16, MODE_S32: state_in = ST_PUSH;
                  MODE_DSD:           state_in = window_done ? ST_LOAD : ST_IDLE;
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (div_last) begin
               state_in = (!chan_ff && stereo) ? ST_LOAD : ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in      = mode_ff;
      chans_in     = chans_ff;
      dec_in       = dec_ff;
      ones_l_in    = ones_l_ff;
      ones_r_in    = ones_r_ff;
      frames_in    = frames_ff;
      chan_in      = chan_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      lsamp_in     = lsamp_ff;
      rsamp_in     = rsamp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (mode_ff)
                  MODE_S16: begin
                     lsamp_in = req_data.left_word[15:0];
                     rsamp_in = stereo ? req_data.right_word[15:0]
                                       : req_data.left_word[15:0];
                  end
                  MODE_S32: begin
                     lsamp_in = req_data.left_word[31:16];
                     rsamp_in = stereo ? req_data.right_word[31:16]
                                       : req_data.left_word[31:16];
                  end
                  MODE_DSD: begin
                     ones_l_in = ones_l_ff + CW'(popcount32(req_data.left_word));
                     if (stereo) begin
                        ones_r_in = ones_r_ff + CW'(popcount32(req_data.right_word));
                     end
                     frames_in = frames_next;
                     chan_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: begin
            neg_in  = cnt_neg;
            rem_in  = num[16 +: DVW];
            low_in  = num[15:0];
            step_in = '0;
         end
         ST_DIV: begin
            rem_in  = ge ? diff[DVW-1:0] : trial[DVW-1:0];
            low_in  = quot;
            step_in = step_ff + 4'd1;
            if (div_last) begin
               if (chan_ff) begin
                  rsamp_in = level;
               end else begin
                  lsamp_in = level;
                  rsamp_in = level;
               end
               if (chan_ff || !stereo) begin
                  ones_l_in = '0;
                  ones_r_in = '0;
                  frames_in = '0;
               end
               chan_in = 1'b1;
            end
         end
         ST_PUSH: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.left_sample  = lsamp_ff;
               rsp_data_in.right_sample = rsamp_ff;
            end
         end
         default: ;
      endcase

      if (cfg_hit) begin
         unique case (csr_index)
            REG_FORMAT_MODE:   mode_in  = csr_wdata[1:0];
            REG_CHANNEL_COUNT: chans_in = csr_wdata[1:0];
            REG_DECIMATION:    dec_in   = csr_wdata;
            default: ;
         endcase
         ones_l_in = '0;
         ones_r_in = '0;
         frames_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= RESET_FORMAT_MODE;
         chans_ff     <= RESET_CHANNEL_COUNT;
         dec_ff       <= RESET_DECIMATION;
         ones_l_ff    <= '0;
         ones_r_ff    <= '0;
         frames_ff    <= '0;
         chan_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         chans_ff     <= chans_in;
         dec_ff       <= dec_in;
         ones_l_ff    <= ones_l_in;
         ones_r_ff    <= ones_r_in;
         frames_ff    <= frames_in;
         chan_ff      <= chan_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      lsamp_ff    <= lsamp_in;
      rsamp_ff    <= rsamp_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_frames_below_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (frames_ff < n_eff))
      else $error("frame count reached window while idle");

   a_step_only_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> (step_ff == '0))
      else $error("divider step count left nonzero");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < divisor))
      else $error("divider remainder out of range");

   a_result_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_PUSH))
      else $error("result raised outside push state");
`endif

endmodule

// ===== bench/dsd_pcm_meter_decimator_test.sv =====
// Testbench for dsd_pcm_meter_decimator: random and directed frames checked against an inline meter model.
module dsd_pcm_meter_decimator_test;
   import dsdpm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DECIM_CAP = 64;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam logic [6:0] CH_MONO   = 7'd1;
   localparam logic [6:0] CH_STEREO = 7'd2;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned RANDOM_FRAMES = 850;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // meter model state
   logic [1:0] cfg_mode;
   logic [1:0] cfg_chans;
   logic [6:0] cfg_decim;
   int unsigned ones_l, ones_r, frames_cnt;

   req_payload_type frames_pending[$];
   rsp_payload_type levels_due[$];
   rsp_payload_type next_level, want;
   int unsigned send_wait = 0, recv_wait = 0;
   int unsigned choke_left = 0;
   bit choke_go = 1'b0;
   bit send_idle = 1'b0, recv_idle = 1'b0;
   int unsigned fail_count = 0;

   dsd_pcm_meter_decimator #(.MAX_DECIMATION(DECIM_CAP)) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic signed [15:0] dsd_level(input int unsigned ones,
                                                    input int unsigned frames);
      longint d, q;
      d = longint'(ones) - 16 * longint'(frames);
      q = (d * 32767) / (8 * longint'(frames));
      if (q > 32767) q = 32767;
      else if (q < -32767) q = -32767;
      return q[15:0];
   endfunction

   function automatic bit meter_frame(input req_payload_type f, output rsp_payload_type lv);
      bit stereo;
      int unsigned n;
      stereo = cfg_chans >= 2'd2;
      lv = '0;
      case (cfg_mode)
         MODE_NONE: return 1'b0;
         MODE_S16: begin
            lv.left_sample = f.left_word[15:0];
            lv.right_sample = stereo ? f.right_word[15:0] : f.left_word[15:0];
            return 1'b1;
         end
         MODE_S32: begin
            lv.left_sample = f.left_word[31:16];
            lv.right_sample = stereo ? f.right_word[31:16] : f.left_word[31:16];
            return 1'b1;
         end
         default: begin
            n = (cfg_decim == 0) ? 1 : ((cfg_decim > DECIM_CAP) ? DECIM_CAP : cfg_decim);
            ones_l += $countones(f.left_word);
            if (stereo) ones_r += $countones(f.right_word);
            frames_cnt++;
            if (frames_cnt < n) return 1'b0;
            lv.left_sample = dsd_level(ones_l, frames_cnt);
            lv.right_sample = stereo ? dsd_level(ones_r, frames_cnt) : lv.left_sample;
            ones_l = 0;
            ones_r = 0;
            frames_cnt = 0;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom & $urandom & $urandom;
         1: return $urandom | $urandom | $urandom;
         2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         3: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (meter_frame(req_data, next_level)) levels_due.push_back(next_level);
         end
         if (!(req_valid && req_stall)) begin
            if (send_wait != 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (frames_pending.size() != 0) begin
               req_data <= frames_pending.pop_front();
               req_valid <= 1'b1;
               send_wait = send_idle ? $urandom_range(0, 12) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (levels_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected level item: %0d/%0d",
                           rsp_data.left_sample, rsp_data.right_sample);
            end else begin
               want = levels_due.pop_front();
               if (rsp_data.left_sample !== want.left_sample ||
                   rsp_data.right_sample !== want.right_sample) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("level mismatch: expected %0d/%0d, got %0d/%0d",
                              want.left_sample, want.right_sample,
                              rsp_data.left_sample, rsp_data.right_sample);
               end
            end
            recv_wait = recv_idle ? $urandom_range(0, 12) : 0;
         end
         rsp_stall <= (choke_left != 0) || (recv_wait != 0);
         if (recv_wait != 0) recv_wait--;
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (choke_go) choke_left <= 300;
      else if (choke_left != 0) choke_left <= choke_left - 1;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [6:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_FORMAT_MODE:   cfg_mode = data[1:0];
         REG_CHANNEL_COUNT: cfg_chans = data[1:0];
         REG_DECIMATION:    cfg_decim = data;
         default: ;
      endcase
      if (idx != REG_UNUSED) begin
         ones_l = 0;
         ones_r = 0;
         frames_cnt = 0;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [6:0] mode_w, input logic [6:0] chans_w,
                             input logic [6:0] decim_w);
      write_reg(REG_FORMAT_MODE, mode_w);
      write_reg(REG_CHANNEL_COUNT, chans_w);
      write_reg(REG_DECIMATION, decim_w);
   endtask

   task automatic offer(input logic [31:0] l, input logic [31:0] r);
      req_payload_type f;
      f.left_word = l;
      f.right_word = r;
      frames_pending.push_back(f);
   endtask

   task automatic settle();
      @(negedge clock);
      while (frames_pending.size() != 0 || req_valid || levels_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned random_sent, phase_no, n_eff, count;
      logic [1:0] mode;
      logic [4:0] junk;
      logic [6:0] chans_w, decim_w;

      cfg_mode = RESET_FORMAT_MODE;
      cfg_chans = RESET_CHANNEL_COUNT;
      cfg_decim = RESET_DECIMATION;
      ones_l = 0;
      ones_r = 0;
      frames_cnt = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // mode none out of reset: nothing comes back
      offer(32'hFFFF_FFFF, 32'h0);
      offer(32'h1234_5678, 32'h8765_4321);
      settle();

      set_config(7'(MODE_S16), CH_STEREO, 7'd1);
      offer(32'h0, 32'h0);
      offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer(32'h0000_7FFF, 32'hFFFF_8000);
      offer(32'h5555_AAAA, 32'hAAAA_5555);
      settle();

      set_config(7'(MODE_S32), CH_STEREO, 7'd1);
      offer(32'h7FFF_0000, 32'h8000_FFFF);
      offer(32'hFFFF_0000, 32'h0000_FFFF);
      settle();

      set_config(7'(MODE_S16), CH_MONO, 7'd1);
      offer(32'h1234_8001, 32'h5678_7FFE);
      settle();
      // channel count zero acts as mono
      set_config(7'(MODE_S16), 7'd0, 7'd1);
      offer(32'h8000_0001, 32'hFFFF_FFFF);
      settle();
      // channel count three acts as stereo
      set_config(7'(MODE_S32), 7'd3, 7'd1);
      offer(32'h8001_0000, 32'h7FFE_0000);
      settle();

      // single-frame windows: saturation both ways, zero, small offsets
      set_config(7'(MODE_DSD), CH_STEREO, 7'd1);
      offer(32'hFFFF_FFFF, 32'h0);
      offer(32'hFFFF_0000, 32'h00FF_FFFF);
      offer(32'h0000_00FF, 32'h0F0F_0F0F);
      offer(32'h0001_FFFF, 32'h0000_7FFF);
      settle();

      // decimation zero acts as one, mono
      set_config(7'(MODE_DSD), CH_MONO, 7'd0);
      offer(32'h0007_FFFF, 32'hAAAA_AAAA);
      settle();

      set_config(7'(MODE_DSD), 7'd3, 7'd3);
      offer(32'hFFFF_FFFF, 32'h0);
      offer(32'hFFFF_FFFF, 32'h0);
      offer(32'h0, 32'hFFFF_FFFF);
      settle();

      // unlisted register index must not clear a partial window
      set_config({5'b11111, MODE_DSD}, CH_STEREO, 7'd2);
      offer(32'h00FF_FFFF, 32'h0000_0FFF);
      settle();
      write_reg(REG_UNUSED, 7'h7F);
      offer(32'hFFFF_FFFF, 32'h0000_0001);
      settle();

      random_sent = 0;
      phase_no = 0;
      while (random_sent < RANDOM_FRAMES) begin
         phase_no++;
         if (phase_no == 3) mode = MODE_S16;
         else if ($urandom_range(0, 9) == 0) mode = MODE_NONE;
         else mode = 2'($urandom_range(1, 3));
         junk = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd0;
         chans_w = 7'($urandom_range(0, 3));
         if ($urandom_range(0, 3) == 0) chans_w[6:2] = 5'($urandom);
         case ($urandom_range(0, 9)) inside
            0, 1, 2, 3, 4, 5: decim_w = 7'($urandom_range(1, 8));
            6: decim_w = 7'd0;
            7: decim_w = 7'(DECIM_CAP);
            8: decim_w = 7'($urandom_range(DECIM_CAP + 1, 127));
            default: decim_w = 7'($urandom_range(9, DECIM_CAP - 1));
         endcase
         n_eff = (decim_w == 0) ? 1 : ((decim_w > DECIM_CAP) ? DECIM_CAP : decim_w);
         send_idle = (phase_no != 3) && ($urandom_range(0, 2) != 0);
         recv_idle = $urandom_range(0, 2) != 0;
         set_config({junk, mode}, chans_w, decim_w);
         if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 7'($urandom));
         if (mode == MODE_DSD)
            count = n_eff * $urandom_range(1, 3) + $urandom_range(0, n_eff - 1);
         else
            count = $urandom_range(10, 40);
         if (phase_no == 3) begin
            count = 60;
            @(posedge clock);
            choke_go <= 1'b1;
            @(posedge clock);
            choke_go <= 1'b0;
         end
         repeat (count) offer(rand_word(), rand_word());
         random_sent += count;
         settle();
      end

      settle();
      if (fail_count == 0 && levels_due.size() == 0)
         $display("PASS dsd_pcm_meter_decimator");
      else
         $display("FAIL dsd_pcm_meter_decimator");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL dsd_pcm_meter_decimator");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/dsdpm_pkg.sv
hdl/dsd_pcm_meter_decimator.sv
bench/dsd_pcm_meter_decimator_test.sv
